/* rtl/hsva_pkg.sv */
// Package with shared types and constants of the HSV saturation and value adjuster.
`timescale 1ns / 1ps
package hsva_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned ScaleW  = 9;
  localparam int unsigned NumW    = 16;
  localparam int unsigned DivBits = 2;
  localparam int unsigned DivStg  = PixW / DivBits;
  localparam logic [ScaleW-1:0] ScaleReset = 9'd256;

  localparam logic [PixW-1:0] HueBaseRed   = 8'd0;
  localparam logic [PixW-1:0] HueBaseGreen = 8'd85;
  localparam logic [PixW-1:0] HueBaseBlue  = 8'd171;
  localparam logic [PixW-1:0] HueSector    = 8'd43;

  typedef enum logic [0:0] {
    CFG_SAT_SCALE = 1'b0,
    CFG_VAL_SCALE = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    REG_0 = 3'd0,
    REG_1 = 3'd1,
    REG_2 = 3'd2,
    REG_3 = 3'd3,
    REG_4 = 3'd4,
    REG_5 = 3'd5
  } region_e;

  // Operands of the two divisions and what travels beside them.
  typedef struct packed {
    logic [NumW-1:0] rem_s;
    logic [PixW-1:0] den_s;
    logic [PixW-1:0] quo_s;
    logic [NumW-1:0] rem_h;
    logic [PixW-1:0] den_h;
    logic [PixW-1:0] quo_h;
    logic [PixW-1:0] val;
    logic [PixW-1:0] base;
    logic            neg;
    logic            grey;
  } div_t;

  // Adjusted HSV triple.
  typedef struct packed {
    logic [PixW-1:0] hue;
    logic [PixW-1:0] sat;
    logic [PixW-1:0] val;
  } hsv_t;

endpackage

/* rtl/hsva_if.sv */
// Valid/ready interfaces for input and output pixel words.
`timescale 1ns / 1ps
interface hsva_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface hsva_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  modport source (output valid, output out_red, output out_green, output out_blue, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue, output ready);
endinterface

/* rtl/hsva_front.sv */
// First stage: max, min, delta and the numerators of the two divisions.
`timescale 1ns / 1ps
module hsva_front import hsva_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [PixW-1:0] red_i,
  input  logic [PixW-1:0] green_i,
  input  logic [PixW-1:0] blue_i,
  output logic            valid_o,
  output div_t            div_o
);

  logic            valid_q;
  div_t            div_d, div_q;
  logic [PixW-1:0] mx, mn, delta, pos, sub;

  always_comb begin
    mx = (red_i > green_i) ? ((red_i > blue_i) ? red_i : blue_i)
                           : ((green_i > blue_i) ? green_i : blue_i);
    mn = (red_i < green_i) ? ((red_i < blue_i) ? red_i : blue_i)
                           : ((green_i < blue_i) ? green_i : blue_i);
    delta = mx - mn;
    if (mx == red_i) begin
      pos = green_i; sub = blue_i; div_d.base = HueBaseRed;
    end else if (mx == green_i) begin
      pos = blue_i;  sub = red_i;  div_d.base = HueBaseGreen;
    end else begin
      pos = red_i;   sub = green_i; div_d.base = HueBaseBlue;
    end
    div_d.neg   = (sub > pos);
    div_d.rem_s = NumW'(delta) * NumW'(255);
    div_d.den_s = mx;
    div_d.quo_s = '0;
    div_d.rem_h = NumW'(div_d.neg ? (sub - pos) : (pos - sub)) * NumW'(HueSector);
    div_d.den_h = delta;
    div_d.quo_h = '0;
    div_d.val   = mx;
    div_d.grey  = (delta == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

/* rtl/hsva_div.sv */
// Pipelined restoring divider for saturation and hue, two quotient bits per stage.
`timescale 1ns / 1ps
module hsva_div import hsva_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  div_t div_i,
  output logic valid_o,
  output div_t div_o
);

  logic [DivStg-1:0] valid_q;
  div_t              stg_q [DivStg];

  for (genvar k = 0; k < DivStg; k++) begin : g_stg
    div_t stg_in, stg_d;
    logic stg_vin;
    logic [NumW+PixW-1:0] cand_s, cand_h;

    if (k == 0) begin : g_first
      assign stg_in  = div_i;
      assign stg_vin = valid_i;
    end else begin : g_next
      assign stg_in  = stg_q[k-1];
      assign stg_vin = valid_q[k-1];
    end

    always_comb begin
      stg_d  = stg_in;
      cand_s = '0;
      cand_h = '0;
      for (int j = 0; j < DivBits; j++) begin
        cand_s = (NumW+PixW)'(stg_d.den_s) << (PixW - 1 - DivBits * k - j);
        cand_h = (NumW+PixW)'(stg_d.den_h) << (PixW - 1 - DivBits * k - j);
        if ((NumW+PixW)'(stg_d.rem_s) >= cand_s) begin
          stg_d.rem_s = stg_d.rem_s - cand_s[NumW-1:0];
          stg_d.quo_s[PixW - 1 - DivBits * k - j] = 1'b1;
        end
        if ((NumW+PixW)'(stg_d.rem_h) >= cand_h) begin
          stg_d.rem_h = stg_d.rem_h - cand_h[NumW-1:0];
          stg_d.quo_h[PixW - 1 - DivBits * k - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= stg_vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= stg_d;
      end
    end
  end

  assign valid_o = valid_q[DivStg-1];
  assign div_o   = stg_q[DivStg-1];

endmodule

/* rtl/hsva_back.sv */
// Hue assembly, scaling and conversion of the HSV triple back to RGB over three stages.
`timescale 1ns / 1ps
module hsva_back import hsva_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  div_t              div_i,
  input  logic [ScaleW-1:0] sat_scale_i,
  input  logic [ScaleW-1:0] val_scale_i,
  output logic              valid_o,
  output logic [PixW-1:0]   red_o,
  output logic [PixW-1:0]   green_o,
  output logic [PixW-1:0]   blue_o
);

  localparam int unsigned ProdW = PixW + ScaleW;

  // Stage A: hue and scaled saturation and value.
  logic             va_q;
  hsv_t             hsv_d, hsv_q;
  logic [ProdW-1:0] sprod, vprod;
  logic [PixW-1:0]  qsig;

  always_comb begin
    qsig  = div_i.neg ? (~div_i.quo_h + 8'd1) : div_i.quo_h;
    sprod = ProdW'(div_i.grey ? '0 : div_i.quo_s) * ProdW'(sat_scale_i);
    vprod = ProdW'(div_i.val) * ProdW'(val_scale_i);
    hsv_d.hue = div_i.grey ? '0 : div_i.base + qsig;
    hsv_d.sat = (sprod[ProdW-1:2*PixW] != '0) ? 8'hFF : sprod[2*PixW-1:PixW];
    hsv_d.val = (vprod[ProdW-1:2*PixW] != '0) ? 8'hFF : vprod[2*PixW-1:PixW];
  end

  // Stage B: region, fractional part and the three factors.
  logic              vb_q;
  region_e           reg_d, reg_q;
  logic [PixW-1:0]   rbase, rem, pf_d, pf_q, qf_d, qf_q, tf_d, tf_q, vb_val_q;
  logic              grey_q;
  logic [2*PixW-1:0] srem, snrem;

  always_comb begin
    if (hsv_q.hue >= 8'd215) begin
      reg_d = REG_5; rbase = 8'd215;
    end else if (hsv_q.hue >= 8'd172) begin
      reg_d = REG_4; rbase = 8'd172;
    end else if (hsv_q.hue >= 8'd129) begin
      reg_d = REG_3; rbase = 8'd129;
    end else if (hsv_q.hue >= 8'd86) begin
      reg_d = REG_2; rbase = 8'd86;
    end else if (hsv_q.hue >= HueSector) begin
      reg_d = REG_1; rbase = HueSector;
    end else begin
      reg_d = REG_0; rbase = 8'd0;
    end
    rem   = (hsv_q.hue - rbase) * 8'd6;
    srem  = (2*PixW)'(hsv_q.sat) * (2*PixW)'(rem);
    snrem = (2*PixW)'(hsv_q.sat) * (2*PixW)'(8'd255 - rem);
    pf_d  = 8'd255 - hsv_q.sat;
    qf_d  = 8'd255 - srem[2*PixW-1:PixW];
    tf_d  = 8'd255 - snrem[2*PixW-1:PixW];
  end

  // Stage C: products and region select into the output register.
  logic              vc_q;
  logic [2*PixW-1:0] pp, qp, tp;
  logic [PixW-1:0]   p, q, t, r_d, g_d, b_d, r_q, g_q, b_q;

  always_comb begin
    pp = (2*PixW)'(vb_val_q) * (2*PixW)'(pf_q);
    qp = (2*PixW)'(vb_val_q) * (2*PixW)'(qf_q);
    tp = (2*PixW)'(vb_val_q) * (2*PixW)'(tf_q);
    p  = pp[2*PixW-1:PixW];
    q  = qp[2*PixW-1:PixW];
    t  = tp[2*PixW-1:PixW];
    if (grey_q) begin
      r_d = vb_val_q; g_d = vb_val_q; b_d = vb_val_q;
    end else begin
      unique case (reg_q)
        REG_0:   begin r_d = vb_val_q; g_d = t; b_d = p; end
        REG_1:   begin r_d = q; g_d = vb_val_q; b_d = p; end
        REG_2:   begin r_d = p; g_d = vb_val_q; b_d = t; end
        REG_3:   begin r_d = p; g_d = q; b_d = vb_val_q; end
        REG_4:   begin r_d = t; g_d = p; b_d = vb_val_q; end
        default: begin r_d = vb_val_q; g_d = p; b_d = q; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hsv_q    <= hsv_d;
      reg_q    <= reg_d;
      pf_q     <= pf_d;
      qf_q     <= qf_d;
      tf_q     <= tf_d;
      vb_val_q <= hsv_q.val;
      grey_q   <= (hsv_q.sat == '0);
      r_q      <= r_d;
      g_q      <= g_d;
      b_q      <= b_d;
    end
  end

  assign valid_o = vc_q;
  assign red_o   = r_q;
  assign green_o = g_q;
  assign blue_o  = b_q;

endmodule

/* rtl/hsv_saturation_value_adjust.sv */
// Top level of the HSV saturation and value adjuster.
// Throughput: one word per cycle; the whole pipeline advances together whenever
// the output register is empty or its word is being taken, so a stall holds every stage.
// Reset clears every valid bit and sets both scale factors to 256 (unity).
`timescale 1ns / 1ps
module hsv_saturation_value_adjust import hsva_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [ScaleW-1:0] cfg_data_i,
  hsva_in_if.sink           pix_i,
  hsva_out_if.source        pix_o
);

  // The scale registers are read by the scaling stage; the user must change them only while the
  // pipeline is empty, so no word sees a mix of old and new factors. The block does not enforce this.
  logic [ScaleW-1:0] sat_scale_q, val_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_scale_q <= ScaleReset;
      val_scale_q <= ScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SAT_SCALE: sat_scale_q <= cfg_data_i;
        CFG_VAL_SCALE: val_scale_q <= cfg_data_i;
        default:       sat_scale_q <= sat_scale_q;
      endcase
    end
  end

  // One shared enable: every stage moves on when the output register can accept.
  logic advance, fr_valid, dv_valid, out_valid;
  div_t fr_div, dv_div;

  assign advance     = !out_valid || pix_o.ready;
  assign pix_i.ready = advance;

  // Front stage: max, min and the two division numerators.
  hsva_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.in_red),
    .green_i (pix_i.in_green),
    .blue_i  (pix_i.in_blue),
    .valid_o (fr_valid),
    .div_o   (fr_div)
  );

  // Four divider stages produce saturation and the hue offset side by side.
  hsva_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .valid_i (fr_valid),
    .div_i   (fr_div),
    .valid_o (dv_valid),
    .div_o   (dv_div)
  );

  // Scaling and the six-region conversion back to RGB; its last stage is the output register.
  hsva_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .valid_i     (dv_valid),
    .div_i       (dv_div),
    .sat_scale_i (sat_scale_q),
    .val_scale_i (val_scale_q),
    .valid_o     (out_valid),
    .red_o       (pix_o.out_red),
    .green_o     (pix_o.out_green),
    .blue_o      (pix_o.out_blue)
  );

  assign pix_o.valid = out_valid;

endmodule
